// ===== hw/rtl/avas_pkg.sv =====
// avas_pkg: shared types and constants of the ATA verify address sequencer.
// Used by avas_div and ata_verify_address_sequencer; depends on nothing.

package avas_pkg;

    // datapath widths
    localparam int LBA_W     = 48;   // logical block address
    localparam int REM_W     = 12;   // divider remainder, divisor up to 255 * 16
    localparam int DIV_CNT_W = 6;    // divider step count, up to LBA_W
    localparam int LOAD_CYL_W = 14;  // cylinder as carried by a load beat
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 9;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 176;

    localparam int CYLINDER_LIMIT_DEF = 16384;

    // addressing modes
    localparam logic [1:0] ADDR_CHS   = 2'd0;
    localparam logic [1:0] ADDR_LBA28 = 2'd1;
    localparam logic [1:0] ADDR_LBA48 = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HPC        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_XFER       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CONTINUOUS = 3'd5;

    // input beat kinds
    localparam logic BEAT_LOAD  = 1'b0;
    localparam logic BEAT_ISSUE = 1'b1;

    // taskfile constants
    localparam logic [7:0] CMD_VERIFY     = 8'h40;
    localparam logic [7:0] CMD_VERIFY_EXT = 8'h42;
    localparam logic [7:0] DEV_CHS        = 8'hA0;
    localparam logic [7:0] DEV_LBA28      = 8'hE0;
    localparam logic [7:0] DEV_LBA48      = 8'h40;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FMT,
        ST_DIV,
        ST_CHS_HEAD,
        ST_CHS_CLAMP,
        ST_CHS_MUL,
        ST_CHS_LBA,
        ST_OUT
    } t_state;

    // which division the shared divider is running
    typedef enum logic [1:0] {
        PH_CHS_SEC,
        PH_CHS_HEAD,
        PH_LBA_CYL,
        PH_LBA_SEC
    } t_phase;

    // divider request: dividend is left aligned, steps = its width in bits
    typedef struct packed {
        logic                 start;
        logic [LBA_W-1:0]     dividend;
        logic [REM_W-1:0]     divisor;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [LBA_W-1:0] quo;
        logic [REM_W-1:0] rem;
    } t_div_rsp;

endpackage

// ===== hw/rtl/avas_div.sv =====
// avas_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on avas_pkg for widths and the request/response structs.

module avas_div
    import avas_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [LBA_W-1:0]     r_quo, n_quo;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [REM_W-1:0]     r_div, n_div;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           ge;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign trial = {r_rem, r_quo[LBA_W-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.divisor;
            n_cnt  = i_req.steps;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[LBA_W-2:0], ge};
            n_rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== hw/rtl/ata_verify_address_sequencer.sv =====
// ata_verify_address_sequencer: READ VERIFY taskfile generator with CHS/LBA tracking.
// Depends on avas_pkg and instantiates the bit-serial divider avas_div.

// A load beat sets the disk position and leaves the sequencer idle. An issue
// beat builds one READ VERIFY taskfile (CHS, LBA28 or LBA48) from the current
// position and then advances it; the result appears on the master side once the
// advance is done. The advance uses the shared bit-serial divider: in LBA modes
// it divides the 48-bit LBA by sectors*heads and then the 12-bit remainder by
// sectors. In CHS mode a sector wrap and a head wrap each add a division of a
// 10-bit value, and a shift-and-add multiply of one step per cylinder bit then
// rebuilds the LBA. The next beat is taken in the cycle the result appears. An
// issue beat with a transfer length of zero gives no result. A finished result
// waits in the output register while the next beat is taken; a second finished
// result holds the sequencer until the first one is taken. The user must write
// configuration only while the block is idle; the block itself does not enforce it.

module ata_verify_address_sequencer
    import avas_pkg::*;
#(
    parameter int CYLINDER_LIMIT = CYLINDER_LIMIT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input beats
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // load_lba[47:0], load_cylinder[61:48], load_head[65:62], load_sector[73:66]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic                  s_axis_tuser,
    // result beats
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // count_reg[8:0], addr_low_reg[24:9], addr_mid_reg[40:25], addr_high_reg[56:41],
    // device_reg[64:57], command_reg[72:65], first_lba[120:73], last_lba[168:121]
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int CYL_CLOG = $clog2(CYLINDER_LIMIT);
    localparam int CYL_W    = (CYL_CLOG > LOAD_CYL_W) ? CYL_CLOG : LOAD_CYL_W;
    localparam int ACC_W    = CYL_W + REM_W;
    localparam int MCNT_W   = $clog2(CYL_W + 1);

    // configuration registers
    logic [1:0] r_cfg_mode;
    logic [7:0] r_cfg_spt;
    logic [4:0] r_cfg_hpc;
    logic [8:0] r_cfg_xfer;
    logic       r_cfg_drive;
    logic       r_cfg_cont;

    // position
    logic [LBA_W-1:0] r_cur_lba, n_cur_lba;
    logic [CYL_W-1:0] r_cur_cyl, n_cur_cyl;
    logic [3:0]       r_cur_head, n_cur_head;
    logic [7:0]       r_cur_sec, n_cur_sec;

    // sequencer and work registers
    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [8:0]         r_tlen, n_tlen;
    logic [M_TDATA_W-1:0] r_res, n_res;
    logic [7:0]         r_sec, n_sec;
    logic [9:0]         r_head, n_head;
    logic [CYL_W:0]     r_cyl, n_cyl;
    logic               r_clamp, n_clamp;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [CYL_W-1:0]   r_msh, n_msh;
    logic [MCNT_W-1:0]  r_mcnt, n_mcnt;

    // output register
    logic                 r_m_tvalid, n_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata, n_m_tdata;

    t_div_req div_req;
    t_div_rsp div_rsp;

    avas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // effective geometry and transfer length
    logic [7:0]  spt_e;
    logic [4:0]  hpc_e;
    logic [12:0] spt_hpc_w;
    logic [REM_W-1:0] spt_hpc;
    logic [8:0]  tlen_base;
    logic [9:0]  sec_sum_now;
    logic [8:0]  tlen_c;
    logic        is_chs;
    logic        is_lba48;

    always_comb begin
        spt_e     = (r_cfg_spt == 8'd0) ? 8'd1 : r_cfg_spt;
        hpc_e     = (r_cfg_hpc == 5'd0) ? 5'd1 : ((r_cfg_hpc > 5'd16) ? 5'd16 : r_cfg_hpc);
        spt_hpc_w = 13'(spt_e) * 13'(hpc_e);
        spt_hpc   = spt_hpc_w[REM_W-1:0];
        tlen_base = (r_cfg_xfer > 9'd256) ? 9'd256 : r_cfg_xfer;
        is_chs    = (r_cfg_mode == ADDR_CHS);
        is_lba48  = (r_cfg_mode == ADDR_LBA48);
        // continuous CHS keeps a command inside the current track
        sec_sum_now = {2'b0, r_cur_sec} + {1'b0, tlen_base};
        tlen_c      = tlen_base;
        if (r_cfg_cont && is_chs && (sec_sum_now > {2'b0, spt_e})) begin
            if (r_cur_sec > spt_e)
                tlen_c = 9'd1;
            else
                tlen_c = {1'b0, spt_e} + 9'd1 - {1'b0, r_cur_sec};
        end
    end

    // input beat fields
    logic [LBA_W-1:0]      ld_lba;
    logic [LOAD_CYL_W-1:0] ld_cyl;
    logic [3:0]            ld_head;
    logic [7:0]            ld_sec;

    assign ld_lba  = s_axis_tdata[47:0];
    assign ld_cyl  = s_axis_tdata[61:48];
    assign ld_head = s_axis_tdata[65:62];
    assign ld_sec  = s_axis_tdata[73:66];

    assign s_axis_tready = (r_state == ST_IDLE);

    // next state and datapath
    always_comb begin
        logic [15:0]      cyl16;
        logic [8:0]       f_count;
        logic [15:0]      f_low, f_mid, f_high;
        logic [7:0]       f_dev, f_cmd;
        logic [LBA_W-1:0] f_last;
        logic [LBA_W-1:0] lba_adv;
        logic [9:0]       sec_n;
        logic [9:0]       sec_m1;
        logic             clamp_c;
        logic [CYL_W-1:0] cyl_f;
        logic [7:0]       sec_f;
        logic [3:0]       head_f;
        logic [11:0]      head_spt;
        logic [ACC_W-1:0] lba_chs;

        n_state    = r_state;
        n_phase    = r_phase;
        n_tlen     = r_tlen;
        n_res      = r_res;
        n_sec      = r_sec;
        n_head     = r_head;
        n_cyl      = r_cyl;
        n_clamp    = r_clamp;
        n_acc      = r_acc;
        n_msh      = r_msh;
        n_mcnt     = r_mcnt;
        n_cur_lba  = r_cur_lba;
        n_cur_cyl  = r_cur_cyl;
        n_cur_head = r_cur_head;
        n_cur_sec  = r_cur_sec;
        n_m_tvalid = r_m_tvalid && !m_axis_tready;
        n_m_tdata  = r_m_tdata;

        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        div_req.steps    = '0;

        cyl16    = 16'(r_cur_cyl);
        f_count  = '0;
        f_low    = '0;
        f_mid    = '0;
        f_high   = '0;
        f_dev    = '0;
        f_cmd    = '0;
        f_last   = r_cur_lba + LBA_W'(r_tlen) - LBA_W'(1);
        lba_adv  = r_cur_lba + LBA_W'(r_tlen);
        sec_n    = {2'b0, r_cur_sec} + {1'b0, r_tlen};
        sec_m1   = sec_n - 10'd1;
        clamp_c  = r_cyl >= (CYL_W + 1)'(CYLINDER_LIMIT);
        cyl_f    = clamp_c ? CYL_W'(CYLINDER_LIMIT - 1) : r_cyl[CYL_W-1:0];
        sec_f    = clamp_c ? spt_e : r_sec;
        head_f   = clamp_c ? 4'(hpc_e - 5'd1) : r_head[3:0];
        head_spt = 12'(r_cur_head) * 12'(spt_e);
        lba_chs  = r_acc + ACC_W'(head_spt) + ACC_W'(r_cur_sec) - ACC_W'(1);

        // taskfile layout from the position at issue
        if (is_lba48) begin
            f_count = r_tlen;
            f_low   = {r_cur_lba[31:24], r_cur_lba[7:0]};
            f_mid   = {r_cur_lba[39:32], r_cur_lba[15:8]};
            f_high  = {r_cur_lba[47:40], r_cur_lba[23:16]};
            f_dev   = DEV_LBA48 | {3'b0, r_cfg_drive, 4'b0};
            f_cmd   = CMD_VERIFY_EXT;
        end else if (is_chs) begin
            f_count = {1'b0, r_tlen[7:0]};
            f_low   = {8'h0, r_cur_sec};
            f_mid   = {8'h0, cyl16[7:0]};
            f_high  = {8'h0, cyl16[15:8]};
            f_dev   = DEV_CHS | {3'b0, r_cfg_drive, r_cur_head};
            f_cmd   = CMD_VERIFY;
        end else begin
            f_count = {1'b0, r_tlen[7:0]};
            f_low   = {8'h0, r_cur_lba[7:0]};
            f_mid   = {8'h0, r_cur_lba[15:8]};
            f_high  = {8'h0, r_cur_lba[23:16]};
            f_dev   = DEV_LBA28 | {3'b0, r_cfg_drive, r_cur_lba[27:24]};
            f_cmd   = CMD_VERIFY;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == BEAT_LOAD) begin
                        n_cur_lba  = ld_lba;
                        n_cur_cyl  = CYL_W'(ld_cyl);
                        n_cur_head = ld_head;
                        n_cur_sec  = ld_sec;
                    end else if (r_cfg_xfer != 9'd0) begin
                        n_tlen  = tlen_c;
                        n_state = ST_FMT;
                    end
                end
            end

            ST_FMT: begin
                n_res = M_TDATA_W'({f_last, r_cur_lba, f_cmd, f_dev,
                                    f_high, f_mid, f_low, f_count});
                if (is_chs) begin
                    if (sec_n > {2'b0, spt_e}) begin
                        // sector wraps into head
                        div_req.start    = 1'b1;
                        div_req.dividend = {sec_m1, (LBA_W - 10)'(0)};
                        div_req.divisor  = REM_W'(spt_e);
                        div_req.steps    = DIV_CNT_W'(10);
                        n_phase          = PH_CHS_SEC;
                        n_state          = ST_DIV;
                    end else begin
                        n_sec   = sec_n[7:0];
                        n_head  = 10'(r_cur_head);
                        n_state = ST_CHS_HEAD;
                    end
                end else begin
                    // LBA: cylinder and remainder from one division
                    n_cur_lba        = lba_adv;
                    div_req.start    = 1'b1;
                    div_req.dividend = lba_adv;
                    div_req.divisor  = spt_hpc;
                    div_req.steps    = DIV_CNT_W'(LBA_W);
                    n_phase          = PH_LBA_CYL;
                    n_state          = ST_DIV;
                end
            end

            ST_DIV: begin
                if (div_rsp.done) begin
                    case (r_phase)
                        PH_CHS_SEC: begin
                            n_sec   = div_rsp.rem[7:0] + 8'd1;
                            n_head  = 10'(r_cur_head) + div_rsp.quo[9:0];
                            n_state = ST_CHS_HEAD;
                        end
                        PH_CHS_HEAD: begin
                            n_head  = 10'(div_rsp.rem);
                            n_cyl   = (CYL_W + 1)'(r_cur_cyl) + (CYL_W + 1)'(div_rsp.quo[9:0]);
                            n_state = ST_CHS_CLAMP;
                        end
                        PH_LBA_CYL: begin
                            n_clamp          = div_rsp.quo >= LBA_W'(CYLINDER_LIMIT);
                            n_cyl            = div_rsp.quo[CYL_W:0];
                            div_req.start    = 1'b1;
                            div_req.dividend = {div_rsp.rem, (LBA_W - REM_W)'(0)};
                            div_req.divisor  = REM_W'(spt_e);
                            div_req.steps    = DIV_CNT_W'(REM_W);
                            n_phase          = PH_LBA_SEC;
                        end
                        PH_LBA_SEC: begin
                            if (r_clamp) begin
                                n_cur_cyl  = CYL_W'(CYLINDER_LIMIT - 1);
                                n_cur_sec  = spt_e;
                                n_cur_head = 4'(hpc_e - 5'd1);
                            end else begin
                                n_cur_cyl  = r_cyl[CYL_W-1:0];
                                n_cur_sec  = div_rsp.rem[7:0] + 8'd1;
                                n_cur_head = div_rsp.quo[3:0];
                            end
                            n_state = ST_OUT;
                        end
                        default: n_state = ST_OUT;
                    endcase
                end
            end

            ST_CHS_HEAD: begin
                if (r_head >= 10'(hpc_e)) begin
                    // head wraps into cylinder
                    div_req.start    = 1'b1;
                    div_req.dividend = {r_head, (LBA_W - 10)'(0)};
                    div_req.divisor  = REM_W'(hpc_e);
                    div_req.steps    = DIV_CNT_W'(10);
                    n_phase          = PH_CHS_HEAD;
                    n_state          = ST_DIV;
                end else begin
                    n_cyl   = (CYL_W + 1)'(r_cur_cyl);
                    n_state = ST_CHS_CLAMP;
                end
            end

            ST_CHS_CLAMP: begin
                // commit CHS, then rebuild the LBA from it
                n_cur_cyl  = cyl_f;
                n_cur_sec  = sec_f;
                n_cur_head = head_f;
                n_acc      = '0;
                n_msh      = cyl_f;
                n_mcnt     = MCNT_W'(CYL_W);
                n_state    = ST_CHS_MUL;
            end

            ST_CHS_MUL: begin
                // cylinder * sectors * heads, one cylinder bit per cycle
                n_acc  = {r_acc[ACC_W-2:0], 1'b0}
                       + (r_msh[CYL_W-1] ? ACC_W'(spt_hpc) : ACC_W'(0));
                n_msh  = {r_msh[CYL_W-2:0], 1'b0};
                n_mcnt = r_mcnt - MCNT_W'(1);
                if (r_mcnt == MCNT_W'(1))
                    n_state = ST_CHS_LBA;
            end

            ST_CHS_LBA: begin
                n_cur_lba = LBA_W'(lba_chs);
                n_state   = ST_OUT;
            end

            ST_OUT: begin
                if (!r_m_tvalid || m_axis_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = r_res;
                    n_state    = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_CHS_SEC;
            r_m_tvalid <= 1'b0;
            r_cur_lba  <= '0;
            r_cur_cyl  <= '0;
            r_cur_head <= '0;
            r_cur_sec  <= 8'd1;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_m_tvalid <= n_m_tvalid;
            r_cur_lba  <= n_cur_lba;
            r_cur_cyl  <= n_cur_cyl;
            r_cur_head <= n_cur_head;
            r_cur_sec  <= n_cur_sec;
        end
        r_tlen    <= n_tlen;
        r_res     <= n_res;
        r_sec     <= n_sec;
        r_head    <= n_head;
        r_cyl     <= n_cyl;
        r_clamp   <= n_clamp;
        r_acc     <= n_acc;
        r_msh     <= n_msh;
        r_mcnt    <= n_mcnt;
        r_m_tdata <= n_m_tdata;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode  <= ADDR_CHS;
            r_cfg_spt   <= 8'd63;
            r_cfg_hpc   <= 5'd16;
            r_cfg_xfer  <= 9'd1;
            r_cfg_drive <= 1'b0;
            r_cfg_cont  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ADDR_MODE:  r_cfg_mode  <= i_cfg_data[1:0];
                REG_SPT:        r_cfg_spt   <= i_cfg_data[7:0];
                REG_HPC:        r_cfg_hpc   <= i_cfg_data[4:0];
                REG_XFER:       r_cfg_xfer  <= i_cfg_data[8:0];
                REG_DRIVE:      r_cfg_drive <= i_cfg_data[0];
                REG_CONTINUOUS: r_cfg_cont  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

endmodule
